@@ src/lsws_pkg.sv @@
package lsws_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    localparam logic [OP_W-1:0] OP_PEEK   = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd1;
    localparam logic [OP_W-1:0] OP_POP    = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     push;
        logic                     pop;
        logic                     clear;
        logic                     search;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

@@ src/lsws_cell.sv @@
module lsws_cell
    import lsws_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cell_cmd_t                cmd,
    input  logic signed [DATA_W-1:0] above_data,
    input  logic                     above_occ,
    input  logic signed [DATA_W-1:0] below_data,
    input  logic                     below_occ,
    output logic signed [DATA_W-1:0] data,
    output logic                     occ,
    output logic                     match
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     occ_reg;
    logic                     occ_next;
    logic                     match_reg;
    logic                     match_next;

    always_comb begin
        data_next  = data_reg;
        occ_next   = occ_reg;
        match_next = match_reg;
        if (cmd.search) begin
            match_next = occ_reg && (data_reg == cmd.value);
        end
        if (cmd.push) begin
            data_next = above_data;
            occ_next  = above_occ;
        end else if (cmd.pop) begin
            data_next = below_data;
            occ_next  = below_occ;
        end else if (cmd.clear) begin
            occ_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            occ_reg   <= occ_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign occ   = occ_reg;
    assign match = match_reg;

endmodule

@@ src/lifo_stack_with_search_top.sv @@
// Bounded LIFO stack of signed 32-bit words built as a row of STACK_DEPTH cells, with
// cell 0 holding the top word. A push shifts every word one cell deeper, a pop shifts
// every word one cell up, and a search compares all cells at once with one comparator
// per cell. An accepted transfer updates the cells; its result passes a pending register
// and then the output register. A new transfer is taken every cycle as long as the result
// side keeps up. fill_count shows the count modulo 32 when STACK_DEPTH exceeds 31.
module lifo_stack_with_search_top
    import lsws_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [OP_W-1:0]            s_op,
    input  logic signed [DATA_W-1:0]   s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [DATA_W-1:0]   m_data_out,
    output logic                       m_found,
    output logic [FILL_W-1:0]          m_fill_count
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic signed [DATA_W-1:0] cell_data [STACK_DEPTH];
    logic [STACK_DEPTH-1:0]   cell_occ;
    logic [STACK_DEPTH-1:0]   cell_match;
    cell_cmd_t                cmd;

    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     pend_reg;
    logic [STATUS_W-1:0]      pend_status_reg;
    logic [STATUS_W-1:0]      pend_status_next;
    logic signed [DATA_W-1:0] pend_data_reg;
    logic signed [DATA_W-1:0] pend_data_next;
    logic                     pend_search_reg;
    logic [FILL_W-1:0]        pend_fill_reg;
    logic [CNT_W+FILL_W-1:0]  cnt_ext;

    logic                     m_valid_reg;
    logic [STATUS_W-1:0]      m_status_reg;
    logic signed [DATA_W-1:0] m_data_out_reg;
    logic                     m_found_reg;
    logic [FILL_W-1:0]        m_fill_count_reg;

    logic out_free;
    logic out_load;
    logic accept;
    logic empty;
    logic full;

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = pend_reg && out_free;
    assign s_ready  = !pend_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CNT_W'(STACK_DEPTH));

    always_comb begin
        cmd.push   = accept && (s_op == OP_PUSH) && !full;
        cmd.pop    = accept && (s_op == OP_POP) && !empty;
        cmd.clear  = accept && (s_op == OP_CLEAR);
        cmd.search = accept && (s_op == OP_SEARCH);
        cmd.value  = s_value;

        cnt_next         = cnt_reg;
        pend_status_next = ST_OK;
        pend_data_next   = '0;
        case (s_op)
            OP_PEEK: begin
                if (empty) pend_status_next = ST_EMPTY;
                else       pend_data_next   = cell_data[0];
            end
            OP_PUSH: begin
                if (full) pend_status_next = ST_FULL;
                else      cnt_next         = cnt_reg + CNT_W'(1);
            end
            OP_POP: begin
                if (empty) begin
                    pend_status_next = ST_EMPTY;
                end else begin
                    pend_data_next = cell_data[0];
                    cnt_next       = cnt_reg - CNT_W'(1);
                end
            end
            OP_SEARCH: begin
                if (empty) pend_status_next = ST_EMPTY;
            end
            OP_CLEAR: begin
                if (empty) pend_status_next = ST_EMPTY;
                cnt_next = '0;
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
        cnt_ext = (CNT_W + FILL_W)'(cnt_next);
    end

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] above_data;
        logic                     above_occ;
        logic signed [DATA_W-1:0] below_data;
        logic                     below_occ;

        if (i == 0) begin : g_top
            assign above_data = s_value;
            assign above_occ  = 1'b1;
        end else begin : g_mid
            assign above_data = cell_data[i-1];
            assign above_occ  = cell_occ[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_bottom
            assign below_data = '0;
            assign below_occ  = 1'b0;
        end else begin : g_inner
            assign below_data = cell_data[i+1];
            assign below_occ  = cell_occ[i+1];
        end

        lsws_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .above_data (above_data),
            .above_occ  (above_occ),
            .below_data (below_data),
            .below_occ  (below_occ),
            .data       (cell_data[i]),
            .occ        (cell_occ[i]),
            .match      (cell_match[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) cnt_reg <= cnt_next;
            if (accept)        pend_reg <= 1'b1;
            else if (out_load) pend_reg <= 1'b0;
            if (out_load)      m_valid_reg <= 1'b1;
            else if (m_ready)  m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_status_reg <= pend_status_next;
            pend_data_reg   <= pend_data_next;
            pend_search_reg <= (s_op == OP_SEARCH) && !empty;
            pend_fill_reg   <= cnt_ext[FILL_W-1:0];
        end
        if (out_load) begin
            m_status_reg     <= pend_status_reg;
            m_data_out_reg   <= pend_data_reg;
            m_found_reg      <= pend_search_reg && (|cell_match);
            m_fill_count_reg <= pend_fill_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_data_out   = m_data_out_reg;
    assign m_found      = m_found_reg;
    assign m_fill_count = m_fill_count_reg;

endmodule

@@ src/lsws_checker.sv @@
module lsws_checker
    import lsws_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [STATUS_W-1:0]      m_status,
    input logic signed [DATA_W-1:0] m_data_out,
    input logic                     m_found,
    input logic [FILL_W-1:0]        m_fill_count
);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result transfer withdrawn before acceptance");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_EMPTY || m_status == ST_FULL))
        else $error("unknown status code");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_fill_count == '0 && m_data_out == '0
            && !m_found)
        else $error("empty status with nonzero count, data or found");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_data_out == '0 && !m_found)
        else $error("dropped push returned data or found");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_status == ST_OK && m_fill_count != '0
            && m_data_out == '0)
        else $error("found set on a result that is not a successful search");

endmodule

bind lifo_stack_with_search_top lsws_checker u_lsws_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_data_out   (m_data_out),
    .m_found      (m_found),
    .m_fill_count (m_fill_count)
);

@@ bench/lifo_result_checker.sv @@
module lifo_result_checker
    import lsws_pkg::*;
#(
    parameter int DEPTH = 16
)(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [STATUS_W-1:0]      m_status,
    input  logic signed [DATA_W-1:0] m_data_out,
    input  logic                     m_found,
    input  logic [FILL_W-1:0]        m_fill_count,
    output int                       fail_count,
    output int                       pending_results,
    output int                       checked_results,
    output int                       full_drops,
    output int                       search_hits
);

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data_out;
        logic                     found;
        logic [FILL_W-1:0]        fill_count;
    } stack_result_t;

    logic signed [DATA_W-1:0] stack_words [DEPTH];
    int                       stack_level;
    stack_result_t            expected_results [$];

    task automatic report_mismatch(input string msg);
        $display("%0t: MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    function automatic stack_result_t next_stack_result(input logic [OP_W-1:0] op,
                                                        input logic signed [DATA_W-1:0] value);
        stack_result_t r;
        r        = '0;
        r.status = ST_OK;
        case (op)
            OP_PEEK: begin
                if (stack_level == 0) r.status = ST_EMPTY;
                else r.data_out = stack_words[stack_level-1];
            end
            OP_PUSH: begin
                if (stack_level >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_words[stack_level] = value;
                    stack_level++;
                end
            end
            OP_POP: begin
                if (stack_level == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    stack_level--;
                    r.data_out = stack_words[stack_level];
                end
            end
            OP_SEARCH: begin
                if (stack_level == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int k = 0; k < stack_level; k++) begin
                        if (stack_words[k] == value) r.found = 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                if (stack_level == 0) r.status = ST_EMPTY;
                else stack_level = 0;
            end
            default: begin
            end
        endcase
        r.fill_count = FILL_W'(stack_level);
        return r;
    endfunction

    always @(posedge aclk) begin
        stack_result_t want;
        if (!aresetn) begin
            expected_results.delete();
            stack_level     = 0;
            fail_count      = 0;
            pending_results = 0;
            checked_results = 0;
            full_drops      = 0;
            search_hits     = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with no expected result waiting");
                end else begin
                    want = expected_results.pop_front();
                    checked_results++;
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status: expected %0d, got %0d",
                                                  want.status, m_status));
                    if (m_data_out !== want.data_out)
                        report_mismatch($sformatf("data_out: expected %0d, got %0d",
                                                  want.data_out, m_data_out));
                    if (m_found !== want.found)
                        report_mismatch($sformatf("found: expected %0d, got %0d",
                                                  want.found, m_found));
                    if (m_fill_count !== want.fill_count)
                        report_mismatch($sformatf("fill_count: expected %0d, got %0d",
                                                  want.fill_count, m_fill_count));
                end
            end
            if (s_valid && s_ready) begin
                want = next_stack_result(s_op, s_value);
                if (want.status == ST_FULL) full_drops++;
                if (want.found) search_hits++;
                expected_results.push_back(want);
            end
            pending_results = expected_results.size();
        end
    end

endmodule

@@ bench/lifo_stack_with_search_top_test.sv @@
module lifo_stack_with_search_top_test;
    import lsws_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_ITEMS   = 950;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh80000000;

    logic                     aclk    = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic [OP_W-1:0]          s_op    = OP_PEEK;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                     m_ready = 1'b0;
    logic                     s_ready;
    logic                     m_valid;
    logic [STATUS_W-1:0]      m_status;
    logic signed [DATA_W-1:0] m_data_out;
    logic                     m_found;
    logic [FILL_W-1:0]        m_fill_count;

    int fail_count;
    int pending_results;
    int checked_results;
    int full_drops;
    int search_hits;
    int items_sent  = 0;
    int idle_cycles = 0;
    int gap_run     = 0;

    lifo_stack_with_search_top #(
        .STACK_DEPTH (DEPTH)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_data_out   (m_data_out),
        .m_found      (m_found),
        .m_fill_count (m_fill_count)
    );

    lifo_result_checker #(
        .DEPTH (DEPTH)
    ) checker_inst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_data_out      (m_data_out),
        .m_found         (m_found),
        .m_fill_count    (m_fill_count),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .checked_results (checked_results),
        .full_drops      (full_drops),
        .search_hits     (search_hits)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (gap_run > 0) begin
            gap_run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            gap_run = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            v = $urandom_range(0, 7);
            return v - 4;
        end
        if (r == 4) begin
            case ($urandom_range(0, 3))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0, 1, 2: begin
                if (r < 85) return OP_PUSH;
                if (r < 93) return OP_SEARCH;
                return OP_PEEK;
            end
            3, 4: begin
                if (r < 85) return OP_POP;
                if (r < 93) return OP_PEEK;
                return OP_SEARCH;
            end
            9: return OP_W'($urandom_range(0, 7));
            default: begin
                if (r < 30) return OP_PUSH;
                if (r < 55) return OP_POP;
                if (r < 70) return OP_PEEK;
                if (r < 90) return OP_SEARCH;
                if (r < 95) return OP_CLEAR;
                return OP_W'(OP_CLEAR + 1 + $urandom_range(0, 2));
            end
        endcase
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
        int   gap;
        logic taken;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= value;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        items_sent++;
    endtask

    initial begin
        int stall_left;
        int free_left;
        int cyc;
        int r;
        stall_left = 0;
        free_left  = 0;
        cyc        = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc == 300 || cyc == 1500) begin
                stall_left = 80;
                free_left  = 0;
            end
            if (stall_left == 0 && free_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 6) free_left = $urandom_range(20, 60);
                else if (r < 9) stall_left = $urandom_range(10, 30);
                else if (r < 35) stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (free_left > 0) free_left--;
            end
        end
    end

    initial begin
        int mode;
        int len;
        int sent_random;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(OP_PEEK, '0);
        send_item(OP_POP, WORD_MAX);
        send_item(OP_SEARCH, '0);
        send_item(OP_CLEAR, -1);
        for (int k = 1; k <= 3; k++) send_item(OP_W'(OP_CLEAR + k), WORD_MIN);
        send_item(OP_PUSH, WORD_MAX);
        send_item(OP_PUSH, WORD_MIN);
        send_item(OP_PUSH, '0);
        send_item(OP_PUSH, -1);
        send_item(OP_PEEK, '0);
        send_item(OP_SEARCH, WORD_MIN);
        send_item(OP_SEARCH, 32'sd12345);
        send_item(OP_POP, '0);
        for (int k = 0; k < DEPTH - 3; k++) send_item(OP_PUSH, k * 1000 - 5000);
        send_item(OP_PUSH, 32'sd77);
        send_item(OP_SEARCH, WORD_MAX);
        send_item(OP_CLEAR, '0);

        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 9);
            len  = $urandom_range(4, 24);
            for (int k = 0; k < len && sent_random < RANDOM_ITEMS; k++) begin
                send_item(pick_op(mode), pick_value());
                sent_random++;
            end
        end
        s_valid <= 1'b0;

        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);
        repeat (5) @(posedge aclk);

        $display("Run covered %0d input transfers and %0d checked results,", items_sent,
                 checked_results);
        $display("including %0d pushes dropped on a full stack and %0d search hits.",
                 full_drops, search_hits);
        if (fail_count == 0 && pending_results == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/lsws_pkg.sv
src/lsws_cell.sv
src/lifo_stack_with_search_top.sv
src/lsws_checker.sv
bench/lifo_result_checker.sv
bench/lifo_stack_with_search_top_test.sv
